@@ rtl/rrts_pkg.sv @@
`default_nettype none

package rrts_pkg;

	localparam int TICK_W  = 16;
	localparam int SLICE_W = 8;
	localparam int OUT_SLOT_W = 4;

	localparam logic [SLICE_W-1:0] SLICE_RESET = 8'd16;
	localparam logic [SLICE_W-1:0] SLICE_MAX   = 8'd255;

	localparam logic [1:0] OP_TICK  = 2'd0;
	localparam logic [1:0] OP_FORK  = 2'd1;
	localparam logic [1:0] OP_SLEEP = 2'd2;
	localparam logic [1:0] OP_EXIT  = 2'd3;

	localparam logic STATUS_DONE      = 1'b0;
	localparam logic STATUS_FORK_FAIL = 1'b1;

	typedef enum logic [1:0] {
		SLOT_DEAD     = 2'd0,
		SLOT_RUNNABLE = 2'd1,
		SLOT_RUNNING  = 2'd2,
		SLOT_BLOCKED  = 2'd3
	} slot_state_t;

	typedef struct packed {
		logic [1:0]        opcode;
		logic [TICK_W-1:0] sleep_ticks;
	} in_item_t;

	typedef struct packed {
		logic                  status;
		logic [OUT_SLOT_W-1:0] child_slot;
		logic [OUT_SLOT_W-1:0] running_slot_out;
		logic                  switched;
	} out_item_t;

endpackage

`default_nettype wire

@@ rtl/rrts_ram.sv @@
`default_nettype none

module rrts_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output      logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

@@ rtl/round_robin_task_scheduler_core.sv @@
// Tick, sleep and exit: the result is registered after the input transfer through the states
// S_PREP, S_CUR, S_SCAN, S_FIN and S_OUT, with S_FIN2 between S_FIN and S_OUT when the pass
// switches slots. The slot scan visits one slot per cycle through the shared countdown unit
// and the sleep-count RAM port. Fork first searches for a free slot at one slot per cycle,
// starting at slot 1; a failed fork answers once that search finds no free slot. One item is
// in flight at a time: the next transfer is taken only after the result, and result stalls delay it.
`default_nettype none

module round_robin_task_scheduler_core #(
	parameter int SLOTS = 16
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output      logic               in_stall,
	input  wire rrts_pkg::in_item_t in_item,
	output      logic               out_valid,
	input  wire logic               out_stall,
	output      rrts_pkg::out_item_t out_item,
	input  wire logic               cfg_wen,
	input  wire logic [7:0]         cfg_wdata
);

	localparam int IW = $clog2(SLOTS);
	localparam logic [IW-1:0] LAST_IDX = IW'(SLOTS - 1);

	typedef enum logic [2:0] {
		S_IDLE,
		S_FSCAN,
		S_PREP,
		S_CUR,
		S_SCAN,
		S_FIN,
		S_FIN2,
		S_OUT
	} fsm_t;

	fsm_t                                state_q;
	rrts_pkg::slot_state_t               slot_st_q [SLOTS];
	logic [1:0]                          op_q;
	logic [rrts_pkg::TICK_W-1:0]         ticks_q;
	logic [IW-1:0]                       idx_q;
	logic [IW-1:0]                       cur_q;
	logic [IW-1:0]                       pick_q;
	logic                                pick_ok_q;
	logic [IW-1:0]                       child_q;
	logic                                fail_q;
	logic                                sw_q;
	logic [rrts_pkg::SLICE_W-1:0]        slice_q;
	logic [rrts_pkg::SLICE_W-1:0]        slice_len_q;
	logic                                out_valid_q;
	rrts_pkg::out_item_t                 out_item_q;

	logic [IW-1:0]                       rd_addr;
	rrts_pkg::slot_state_t               st_rd;
	logic                                ram_we;
	logic [IW-1:0]                       ram_waddr;
	logic [rrts_pkg::TICK_W-1:0]         ram_wdata;
	logic [IW-1:0]                       ram_raddr;
	logic [rrts_pkg::TICK_W-1:0]         ram_rdata;
	logic                                wake;
	logic                                out_free;

	assign in_stall  = (state_q != S_IDLE);
	assign out_valid = out_valid_q;
	assign out_item  = out_item_q;
	assign out_free  = !out_valid_q || !out_stall;

	assign rd_addr = (state_q == S_FSCAN || state_q == S_SCAN) ? idx_q : cur_q;
	assign st_rd   = slot_st_q[rd_addr];
	// A blocked slot with a count of zero or one wakes in this pass.
	assign wake    = (ram_rdata[rrts_pkg::TICK_W-1:1] == '0);

	// The sleep counts are read one slot ahead so that the data for slot idx_q
	// arrives in the cycle that slot is processed.
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = idx_q;
		ram_wdata = '0;
		ram_raddr = idx_q + IW'(1);
		case (state_q)
			S_PREP: begin
				if (op_q == rrts_pkg::OP_FORK) begin
					ram_we    = 1'b1;
					ram_waddr = child_q;
				end else if (op_q == rrts_pkg::OP_SLEEP) begin
					ram_we    = 1'b1;
					ram_waddr = cur_q;
					ram_wdata = ticks_q;
				end
			end
			S_CUR: begin
				ram_raddr = '0;
			end
			S_SCAN: begin
				if (st_rd == rrts_pkg::SLOT_BLOCKED) begin
					ram_we    = 1'b1;
					ram_wdata = wake ? '0 : ram_rdata - rrts_pkg::TICK_W'(1);
				end
			end
			default: begin
			end
		endcase
	end

	rrts_ram #(
		.WIDTH(rrts_pkg::TICK_W),
		.DEPTH(SLOTS)
	) u_sleep_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			for (int i = 0; i < SLOTS; i++) begin
				slot_st_q[i] <= (i == 0) ? rrts_pkg::SLOT_RUNNING : rrts_pkg::SLOT_DEAD;
			end
			op_q        <= rrts_pkg::OP_TICK;
			ticks_q     <= '0;
			idx_q       <= '0;
			cur_q       <= '0;
			pick_q      <= '0;
			pick_ok_q   <= 1'b0;
			child_q     <= '0;
			fail_q      <= 1'b0;
			sw_q        <= 1'b0;
			slice_q     <= '0;
			slice_len_q <= rrts_pkg::SLICE_RESET;
			out_valid_q <= 1'b0;
			out_item_q  <= '0;
		end else begin
			if (cfg_wen) begin
				slice_len_q <= cfg_wdata;
			end
			if (out_valid_q && !out_stall && state_q != S_OUT) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						op_q    <= in_item.opcode;
						ticks_q <= in_item.sleep_ticks;
						child_q <= '0;
						fail_q  <= rrts_pkg::STATUS_DONE;
						sw_q    <= 1'b0;
						idx_q   <= IW'(1);
						state_q <= (in_item.opcode == rrts_pkg::OP_FORK) ? S_FSCAN : S_PREP;
					end
				end
				S_FSCAN: begin
					if (st_rd == rrts_pkg::SLOT_DEAD) begin
						child_q <= idx_q;
						state_q <= S_PREP;
					end else if (idx_q == LAST_IDX) begin
						// No free slot: the fork fails and leaves everything as it was.
						fail_q  <= rrts_pkg::STATUS_FORK_FAIL;
						state_q <= S_OUT;
					end else begin
						idx_q <= idx_q + IW'(1);
					end
				end
				S_PREP: begin
					case (op_q)
						rrts_pkg::OP_FORK: begin
							slot_st_q[child_q] <= rrts_pkg::SLOT_RUNNABLE;
						end
						rrts_pkg::OP_SLEEP: begin
							slot_st_q[cur_q] <= rrts_pkg::SLOT_BLOCKED;
							slice_q          <= slice_len_q;
						end
						rrts_pkg::OP_EXIT: begin
							slot_st_q[cur_q] <= rrts_pkg::SLOT_DEAD;
							slice_q          <= slice_len_q;
						end
						default: begin
						end
					endcase
					state_q <= S_CUR;
				end
				S_CUR: begin
					if (st_rd == rrts_pkg::SLOT_RUNNING && slice_q != rrts_pkg::SLICE_MAX) begin
						slice_q <= slice_q + rrts_pkg::SLICE_W'(1);
					end
					idx_q     <= '0;
					pick_ok_q <= 1'b0;
					state_q   <= S_SCAN;
				end
				S_SCAN: begin
					if (st_rd == rrts_pkg::SLOT_BLOCKED) begin
						if (wake) begin
							slot_st_q[idx_q] <= rrts_pkg::SLOT_RUNNABLE;
							pick_q           <= idx_q;
							pick_ok_q        <= 1'b1;
						end
					end else if (st_rd == rrts_pkg::SLOT_RUNNABLE) begin
						pick_q    <= idx_q;
						pick_ok_q <= 1'b1;
					end
					if (idx_q == LAST_IDX) begin
						state_q <= S_FIN;
					end else begin
						idx_q <= idx_q + IW'(1);
					end
				end
				S_FIN: begin
					if (slice_q >= slice_len_q && pick_ok_q) begin
						// Demote the old slot first so a re-chosen slot ends up running.
						if (st_rd == rrts_pkg::SLOT_RUNNING) begin
							slot_st_q[cur_q] <= rrts_pkg::SLOT_RUNNABLE;
						end
						slice_q <= '0;
						sw_q    <= 1'b1;
						state_q <= S_FIN2;
					end else begin
						if (slice_q >= slice_len_q && (st_rd == rrts_pkg::SLOT_RUNNING ||
						                               st_rd == rrts_pkg::SLOT_RUNNABLE)) begin
							slice_q <= '0;
						end
						state_q <= S_OUT;
					end
				end
				S_FIN2: begin
					slot_st_q[pick_q] <= rrts_pkg::SLOT_RUNNING;
					cur_q             <= pick_q;
					state_q           <= S_OUT;
				end
				S_OUT: begin
					if (out_free) begin
						out_valid_q                 <= 1'b1;
						out_item_q.status           <= fail_q;
						out_item_q.child_slot       <= rrts_pkg::OUT_SLOT_W'(child_q);
						out_item_q.running_slot_out <= rrts_pkg::OUT_SLOT_W'(cur_q);
						out_item_q.switched         <= sw_q;
						state_q                     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

`default_nettype wire
